// ===== hw/rtl/ermf_pkg.sv =====
// Shared types and constants for the echo range median filter.
// No dependencies; every other file of the block but ermf_ram imports this package.
package ermf_pkg;

  // Default values for the top-level parameters.
  localparam int CHANNELS_DEF       = 6;
  localparam int WINDOW_LEN_DEF     = 10;
  localparam int MEDIAN_RANK_DEF    = 5;
  localparam int TICKS_PER_UNIT_DEF = 56;

  // Fixed field widths.
  localparam int CH_W       = 3;
  localparam int TICKS_W    = 16;
  localparam int DIST_W     = 8;
  localparam int TOL_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [TICKS_W-1:0] WINDOW_LOW_RST  = 16'd500;
  localparam logic [TICKS_W-1:0] WINDOW_HIGH_RST = 16'd3250;
  localparam logic [TOL_W-1:0]   OUTLIER_TOL_RST = 8'd5;

  // Distance codes.
  localparam logic [DIST_W-1:0] NO_ECHO  = 8'hFF;
  localparam logic [DIST_W-1:0] MAX_DIST = 8'hFE;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW,
    CFG_WINDOW_HIGH,
    CFG_OUTLIER_TOL
  } ermf_cfg_reg_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RAW,
    ST_DONE
  } ermf_state_e;

endpackage

// ===== hw/rtl/ermf_if.sv =====
// Handshake channels of the echo range median filter: capture requests,
// filtered results and register writes. Depends on ermf_pkg.
interface ermf_in_if import ermf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel;
  logic [TICKS_W-1:0] echo_ticks;

  modport source (output valid, output channel, output echo_ticks, input ready);
  modport sink   (input valid, input channel, input echo_ticks, output ready);
endinterface

interface ermf_out_if import ermf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic [DIST_W-1:0] distance;
  logic              median_used;

  modport source (output valid, output out_channel, output distance,
                  output median_used, input ready);
  modport sink   (input valid, input out_channel, input distance,
                  input median_used, output ready);
endinterface

interface ermf_cfg_if import ermf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ermf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module ermf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/ermf_dist.sv =====
// Raw distance unit: window check and division by the tick scale through a
// reciprocal multiply with one correction step, three register stages.
// Depends on ermf_pkg.
module ermf_dist import ermf_pkg::*; #(
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TICKS_W-1:0] ticks_i,
  input  logic [TICKS_W-1:0] low_i,
  input  logic [TICKS_W-1:0] high_i,
  output logic [DIST_W-1:0]  raw_o
);

  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / TICKS_PER_UNIT);
  localparam int PROD_W = TICKS_W + RECIP_W;
  localparam int TPU_W  = $clog2(TICKS_PER_UNIT + 1);
  localparam int QT_W   = TICKS_W + TPU_W;

  logic               s1_vld_q, s2_vld_q;
  logic               s1_ok_q, s2_ok_q;
  logic [TICKS_W-1:0] s1_d_q, s2_d_q;
  logic [PROD_W-1:0]  s1_prod_q;
  logic [TICKS_W-1:0] s2_q0_q;
  logic [QT_W-1:0]    s2_qt_q;

  logic [TICKS_W-1:0] d;
  logic [TICKS_W-1:0] q0;
  logic [QT_W-1:0]    rem;
  logic [TICKS_W:0]   quot;
  logic [DIST_W-1:0]  raw_d;

  assign d  = ticks_i - low_i;
  assign q0 = s1_prod_q[RECIP_SHIFT +: TICKS_W];

  // The estimate is the quotient or one below it; the remainder decides.
  always_comb begin
    rem  = QT_W'(s2_d_q) - s2_qt_q;
    quot = {1'b0, s2_q0_q} + ((rem >= QT_W'(TICKS_PER_UNIT)) ? 17'd1 : 17'd0);
    if (!s2_ok_q) begin
      raw_d = NO_ECHO;
    end else if (quot > (TICKS_W+1)'(MAX_DIST)) begin
      raw_d = MAX_DIST;
    end else begin
      raw_d = quot[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_ok_q   <= (ticks_i > low_i) && (ticks_i < high_i);
      s1_d_q    <= d;
      s1_prod_q <= PROD_W'(d) * PROD_W'(RECIP);
    end
    if (s1_vld_q) begin
      s2_ok_q <= s1_ok_q;
      s2_d_q  <= s1_d_q;
      s2_q0_q <= q0;
      s2_qt_q <= QT_W'(q0) * QT_W'(TICKS_PER_UNIT);
    end
    if (s2_vld_q) begin
      raw_o <= raw_d;
    end
  end

endmodule

// ===== hw/rtl/echo_range_median_filter_top.sv =====
// Echo range median filter, top level. Depends on ermf_pkg, the channel
// interfaces, ermf_ram and ermf_dist.
//
// Each capture request carries a channel and an echo tick count. A count
// strictly between window_low and window_high becomes a raw distance
// (ticks - window_low) / TICKS_PER_UNIT, saturated to 254; any other count
// gives the no-echo code 255. The raw value and the last WINDOW_LEN-1 raw
// values of that channel form the window whose MEDIAN_RANK-th smallest entry
// is the median. The median is reported when it differs from the raw value by
// more than outlier_tolerance, else the raw value; the raw value always enters
// the history. Requests for a channel at or above CHANNELS are accepted and
// dropped without a result. One request is handled at a time: the history
// of the channel sits in one RAM with a single read port, so its WINDOW_LEN-1
// entries are read one per cycle and inserted into a sorted register row as
// they arrive, then the raw value is inserted, then the result is loaded and
// the raw value written back. The division runs in parallel with the history
// reads. The result sits in an output register, so the next request is taken
// while an earlier result still waits. History rows are kept as ring buffers;
// per-channel fill state makes entries never written read as zero, so no
// clearing pass is needed after reset. Configuration writes are always
// accepted and must only be issued while the block is idle.
module echo_range_median_filter_top import ermf_pkg::*; #(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int WINDOW_LEN     = WINDOW_LEN_DEF,
  parameter int MEDIAN_RANK    = MEDIAN_RANK_DEF,
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ermf_in_if.sink    in_i,
  ermf_out_if.source res_o,
  ermf_cfg_if.sink   cfg_i
);

  localparam int HIST     = WINDOW_LEN - 1;
  localparam int DEPTH    = CHANNELS * HIST;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W   = $clog2(HIST);
  localparam int CNT_W    = $clog2(HIST + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RANK     = (MEDIAN_RANK < 1) ? 1 :
                            ((MEDIAN_RANK > WINDOW_LEN) ? WINDOW_LEN : MEDIAN_RANK);
  localparam int KEY_W    = DIST_W + 1;
  localparam logic [KEY_W-1:0] KEY_EMPTY = {1'b1, {DIST_W{1'b0}}};

  ermf_state_e state_q, state_d;

  // Configuration registers.
  logic [TICKS_W-1:0] win_low_q, win_high_q;
  logic [TOL_W-1:0]   tol_q;

  // Request context.
  logic [CH_W-1:0]     ch_q, ch_d;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [CNT_W-1:0]    iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]   rd_slot_q, rd_slot_d;

  // Per-channel ring pointer and fill flag.
  logic [SLOT_W-1:0] wp_q [CHANNELS];
  logic              wrap_q [CHANNELS];
  logic              ring_upd;

  // Sorted window, ascending; empty lanes hold a key above every distance.
  logic [KEY_W-1:0] lane_q [WINDOW_LEN];
  logic [KEY_W-1:0] lane_d [WINDOW_LEN];
  logic [KEY_W-1:0] ins_lane [WINDOW_LEN];
  logic [KEY_W-1:0] ins_val;
  logic             ins_en, lane_clr;

  // Output register.
  logic              out_vld_q, out_vld_d, out_load;
  logic [CH_W-1:0]   out_ch_q;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_med_q, out_med_d;

  // RAM and distance unit.
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [DIST_W-1:0] mem_rdata;
  logic [DIST_W-1:0] raw;
  logic              dist_start;
  logic              in_fire, ch_ok;

  logic [DIST_W-1:0] med, diff;
  logic              slot_written;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign ch_ok       = (int'(in_i.channel) < CHANNELS);
  assign dist_start  = in_fire && ch_ok;
  assign cfg_i.ready = 1'b1;

  assign ch_idx = CH_IDX_W'(ch_q);

  assign res_o.valid       = out_vld_q;
  assign res_o.out_channel = out_ch_q;
  assign res_o.distance    = out_dist_q;
  assign res_o.median_used = out_med_q;

  ermf_ram #(
    .WIDTH  (DIST_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (raw),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ermf_dist #(
    .TICKS_PER_UNIT (TICKS_PER_UNIT)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .ticks_i (in_i.echo_ticks),
    .low_i   (win_low_q),
    .high_i  (win_high_q),
    .raw_o   (raw)
  );

  // A ring slot holds data once the pointer has passed it or the ring wrapped.
  assign slot_written = wrap_q[ch_idx] || (rd_slot_q < wp_q[ch_idx]);

  // One insertion into the sorted row; each lane looks only at itself and
  // its lower neighbor.
  always_comb begin
    ins_lane[0] = (lane_q[0] <= ins_val) ? lane_q[0] : ins_val;
    for (int j = 1; j < WINDOW_LEN; j++) begin
      if (lane_q[j] <= ins_val) begin
        ins_lane[j] = lane_q[j];
      end else if (lane_q[j-1] <= ins_val) begin
        ins_lane[j] = ins_val;
      end else begin
        ins_lane[j] = lane_q[j-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if (lane_clr) begin
        lane_d[j] = KEY_EMPTY;
      end else if (ins_en) begin
        lane_d[j] = ins_lane[j];
      end else begin
        lane_d[j] = lane_q[j];
      end
    end
  end

  assign med  = lane_q[RANK-1][DIST_W-1:0];
  assign diff = (med > raw) ? (med - raw) : (raw - med);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_slot_d  = rd_slot_q;
    mem_re     = 1'b0;
    mem_raddr  = ADDR_W'(ch_idx) * ADDR_W'(HIST) + ADDR_W'(iss_q);
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(ch_idx) * ADDR_W'(HIST) + ADDR_W'(wp_q[ch_idx]);
    ins_en     = 1'b0;
    ins_val    = {1'b0, raw};
    lane_clr   = 1'b0;
    out_load   = 1'b0;
    ring_upd   = 1'b0;
    out_dist_d = raw;
    out_med_d  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (dist_start) begin
          ch_d     = in_i.channel;
          iss_d    = '0;
          lane_clr = 1'b1;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        if (iss_q < CNT_W'(HIST)) begin
          mem_re    = 1'b1;
          rd_vld_d  = 1'b1;
          rd_slot_d = iss_q[SLOT_W-1:0];
          iss_d     = iss_q + 1'b1;
        end else begin
          state_d = ST_RAW;
        end
        if (rd_vld_q) begin
          ins_en  = 1'b1;
          ins_val = slot_written ? {1'b0, mem_rdata} : '0;
        end
      end
      ST_RAW: begin
        ins_en  = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (diff > tol_q) begin
          out_dist_d = med;
          out_med_d  = 1'b1;
        end
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          mem_we   = 1'b1;
          ring_upd = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      win_low_q  <= WINDOW_LOW_RST;
      win_high_q <= WINDOW_HIGH_RST;
      tol_q      <= OUTLIER_TOL_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]   <= '0;
        wrap_q[c] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= rd_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_WINDOW_LOW:  win_low_q  <= cfg_i.data;
          CFG_WINDOW_HIGH: win_high_q <= cfg_i.data;
          CFG_OUTLIER_TOL: tol_q      <= cfg_i.data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (ring_upd) begin
        if (wp_q[ch_idx] == SLOT_W'(HIST - 1)) begin
          wp_q[ch_idx]   <= '0;
          wrap_q[ch_idx] <= 1'b1;
        end else begin
          wp_q[ch_idx] <= wp_q[ch_idx] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    iss_q     <= iss_d;
    rd_slot_q <= rd_slot_d;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      lane_q[j] <= lane_d[j];
    end
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_dist_q <= out_dist_d;
      out_med_q  <= out_med_d;
    end
  end

endmodule

// ===== tb/echo_range_median_filter_top_tb.sv =====
// Self-checking testbench for echo_range_median_filter_top: directed table, then random traffic.
// Depends on ermf_pkg, the ermf channel interfaces and the RTL of the block.
module echo_range_median_filter_top_tb;
  import ermf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT        = WINDOW_LEN_DEF + 2;
  localparam int HIST_DEPTH      = WINDOW_LEN_DEF - 1;
  localparam int RANDOM_ITEMS    = 1700;
  localparam int PRESSURE_AT     = 400;
  // Long receiver hold-off used once to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 400;
  // The limit lies well above the longest correct stretch without any
  // handshake, which the long hold-off sets.
  localparam int STALL_LIMIT     = 4000;
  localparam int PRINT_LIMIT     = 20;

  // Index 3 exists on the port but selects no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_CAP, ROW_CFG} row_kind_e;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_BURSTY,
    RDY_RARE_LONG
  } rdy_mode_e;

  typedef enum int {
    SET_DEFAULT,
    SET_FULL,
    SET_RANDOM_WIN,
    SET_ANY,
    SET_EMPTY,
    SET_TOL_EXTREME
  } cfg_mode_e;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] dist_val;
    logic              med;
  } dist_result_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CH_W-1:0]       ch;
    logic [TICKS_W-1:0]    ticks;
    logic                  typed;
    logic [DIST_W-1:0]     dist_val;
    logic                  med;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_row_t;

  localparam int NUM_ROWS = 30;

  // Rows with typed set carry a result that follows directly from the row and
  // the history left by earlier rows; all other rows take the predicted result.
  localparam stim_row_t DIR_TAB [NUM_ROWS] = '{
    // No echo against the cleared history: the zero median replaces it.
    '{ROW_CAP, 3'd0, 16'd0,     1'b1, 8'd0,   1'b1, CFG_WINDOW_LOW,  16'd0},
    // A count equal to the lower bound is outside the window.
    '{ROW_CAP, 3'd0, 16'd500,   1'b1, 8'd0,   1'b1, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd0, 16'd501,   1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd1, 16'd3249,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd1, 16'd3250,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd5, 16'hFFFF,  1'b1, 8'd0,   1'b1, CFG_WINDOW_LOW,  16'd0},
    // Channels at or above six are dropped without a result.
    '{ROW_CAP, 3'd6, 16'd1000,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd7, 16'hFFFF,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    // Widest window and widest tolerance.
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_HIGH, 16'hFFFF},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_OUTLIER_TOL, 16'd255},
    // Large distance saturates to 254.
    '{ROW_CAP, 3'd2, 16'd65534, 1'b1, 8'd254, 1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd2, 16'd1,     1'b1, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd2, 16'd0,     1'b1, 8'd255, 1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd2, 16'hFFFF,  1'b1, 8'd255, 1'b0, CFG_WINDOW_LOW,  16'd0},
    // Zero tolerance; the upper data bits of this register are ignored.
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_OUTLIER_TOL, 16'hFF00},
    '{ROW_CAP, 3'd3, 16'd168,   1'b1, 8'd0,   1'b1, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd3, 16'd55,    1'b1, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    // Empty window with equal bounds.
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd1000},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_HIGH, 16'd1000},
    '{ROW_CAP, 3'd4, 16'd999,   1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd4, 16'd1000,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CAP, 3'd4, 16'd1001,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    // Empty window with crossed extreme bounds.
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'hFFFF},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_HIGH, 16'd0},
    '{ROW_CAP, 3'd4, 16'h8000,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    // A write to the unused index changes nothing.
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_UNUSED,      16'hFFFF},
    '{ROW_CAP, 3'd4, 16'd1500,  1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd0},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_LOW,  16'd500},
    '{ROW_CFG, 3'd0, 16'd0,     1'b0, 8'd0,   1'b0, CFG_WINDOW_HIGH, 16'd3250}
  };

  logic clk = 1'b0;
  logic rst_n;

  ermf_in_if  cap_if ();
  ermf_out_if res_if ();
  ermf_cfg_if cfg_if ();

  echo_range_median_filter_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cap_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk = ~clk;

  // Predictor state: registers and per-channel raw history, newest first.
  logic [TICKS_W-1:0] win_lo;
  logic [TICKS_W-1:0] win_hi;
  logic [TOL_W-1:0]   tol;
  logic [DIST_W-1:0]  raw_hist [CHANNELS_DEF][HIST_DEPTH];

  dist_result_t expected_dist_q [$];

  int fail_count;
  int requests_checked;
  int requests_dropped;
  int results_checked;
  int median_hits;
  int writes_done;
  int burst_left;
  int rand_items;
  int quiet_cycles;
  int track [CHANNELS_DEF];
  bit pressure_go;
  bit pressure_done;

  // Filters one capture for a valid channel and advances that channel's history.
  function automatic dist_result_t predict_filtered(input logic [CH_W-1:0] ch,
                                                    input logic [TICKS_W-1:0] ticks);
    logic [DIST_W-1:0] win [WINDOW_LEN_DEF];
    logic [DIST_W-1:0] raw;
    logic [DIST_W-1:0] med;
    logic [DIST_W-1:0] tmp;
    int q;
    int diff;
    dist_result_t r;
    if (ticks > win_lo && ticks < win_hi) begin
      q = (int'(ticks) - int'(win_lo)) / TICKS_PER_UNIT_DEF;
      raw = (q > int'(MAX_DIST)) ? MAX_DIST : q[DIST_W-1:0];
    end else begin
      raw = NO_ECHO;
    end
    win[0] = raw;
    for (int i = 0; i < HIST_DEPTH; i++) win[i+1] = raw_hist[ch][i];
    for (int i = 1; i < WINDOW_LEN_DEF; i++) begin
      for (int j = i; j > 0; j--) begin
        if (win[j-1] > win[j]) begin
          tmp = win[j-1];
          win[j-1] = win[j];
          win[j] = tmp;
        end
      end
    end
    med = win[MEDIAN_RANK_DEF-1];
    diff = (med > raw) ? int'(med) - int'(raw) : int'(raw) - int'(med);
    r.ch = ch;
    r.med = (diff > int'(tol));
    r.dist_val = r.med ? med : raw;
    for (int i = HIST_DEPTH - 1; i > 0; i--) raw_hist[ch][i] = raw_hist[ch][i-1];
    raw_hist[ch][0] = raw;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Sender pacing: bursts of back-to-back requests separated by random gaps.
  task automatic pace_requests();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        cap_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_request(input logic [CH_W-1:0] ch, input logic [TICKS_W-1:0] ticks,
                              input logic use_typed, input dist_result_t typed_res);
    dist_result_t pred;
    @(negedge clk);
    cap_if.valid      <= 1'b1;
    cap_if.channel    <= ch;
    cap_if.echo_ticks <= ticks;
    do @(posedge clk); while (cap_if.ready !== 1'b1);
    if (ch < CHANNELS_DEF) begin
      pred = predict_filtered(ch, ticks);
      expected_dist_q.push_back(use_typed ? typed_res : pred);
      requests_checked++;
    end else begin
      requests_dropped++;
    end
  endtask

  // Register writes only go out once the block has drained: every expected
  // result has arrived and a dropped request has had time to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cap_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_WINDOW_LOW:  win_lo = data;
      CFG_WINDOW_HIGH: win_hi = data;
      CFG_OUTLIER_TOL: tol    = data[TOL_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Main stimulus: reset, directed table, then random phases of settings.
  initial begin
    cfg_mode_e          mode;
    logic [TICKS_W-1:0] new_lo;
    logic [TICKS_W-1:0] new_hi;
    logic [TICKS_W-1:0] ticks;
    logic [CH_W-1:0]    ch;
    int phase_len;
    int pick;
    int lo_i;
    int hi_i;

    rst_n             = 1'b0;
    cap_if.valid      = 1'b0;
    cap_if.channel    = '0;
    cap_if.echo_ticks = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    win_lo            = WINDOW_LOW_RST;
    win_hi            = WINDOW_HIGH_RST;
    tol               = OUTLIER_TOL_RST;
    foreach (raw_hist[c, i]) raw_hist[c][i] = '0;
    burst_left  = 0;
    rand_items  = 0;
    pressure_go = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        pace_requests();
        send_request(DIR_TAB[i].ch, DIR_TAB[i].ticks, DIR_TAB[i].typed,
                     {DIR_TAB[i].ch, DIR_TAB[i].dist_val, DIR_TAB[i].med});
      end
    end

    while (rand_items < RANDOM_ITEMS) begin
      mode = cfg_mode_e'($urandom_range(0, 5));
      case (mode)
        SET_DEFAULT: begin
          new_lo = WINDOW_LOW_RST;
          new_hi = WINDOW_HIGH_RST;
          write_reg(CFG_OUTLIER_TOL, {8'($urandom), OUTLIER_TOL_RST});
        end
        SET_FULL: begin
          new_lo = '0;
          new_hi = '1;
          write_reg(CFG_OUTLIER_TOL, {8'($urandom), 8'($urandom_range(0, 15))});
        end
        SET_RANDOM_WIN: begin
          new_lo = 16'($urandom_range(0, 4000));
          new_hi = new_lo + 16'($urandom_range(500, 20000));
          write_reg(CFG_OUTLIER_TOL, {8'($urandom), 8'($urandom_range(0, 30))});
        end
        SET_ANY: begin
          new_lo = 16'($urandom);
          new_hi = 16'($urandom);
          write_reg(CFG_OUTLIER_TOL, 16'($urandom));
        end
        SET_EMPTY: begin
          new_lo = 16'($urandom);
          new_hi = 16'($urandom_range(0, new_lo));
          write_reg(CFG_OUTLIER_TOL, {8'($urandom), 8'($urandom_range(0, 10))});
        end
        default: begin
          new_lo = WINDOW_LOW_RST;
          new_hi = WINDOW_HIGH_RST;
          write_reg(CFG_OUTLIER_TOL, ($urandom_range(0, 1) == 1) ? 16'd255 : 16'd0);
        end
      endcase
      write_reg(CFG_WINDOW_LOW, new_lo);
      write_reg(CFG_WINDOW_HIGH, new_hi);

      lo_i = int'(win_lo);
      hi_i = int'(win_hi);
      // Each channel follows a slowly moving target, as a real reflector would.
      foreach (track[c]) begin
        track[c] = (hi_i - lo_i > 2) ? lo_i + 1 + int'($urandom_range(0, hi_i - lo_i - 2)) : 0;
      end

      phase_len = $urandom_range(120, 260);
      for (int n = 0; n < phase_len && rand_items < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        ch = 3'($urandom_range(0, CHANNELS_DEF - 1));
        if (pick < 8) begin
          ch = 3'($urandom_range(CHANNELS_DEF, 7));
          ticks = 16'($urandom);
        end else if (pick < 60 && hi_i - lo_i > 2) begin
          track[ch] = track[ch] + int'($urandom_range(0, 120)) - 60;
          if (track[ch] <= lo_i) track[ch] = lo_i + 1;
          if (track[ch] >= hi_i) track[ch] = hi_i - 1;
          ticks = 16'(track[ch]);
        end else if (pick < 75 && hi_i - lo_i > 2) begin
          // An outlier anywhere inside the window.
          ticks = 16'(lo_i + 1 + int'($urandom_range(0, hi_i - lo_i - 2)));
        end else if (pick < 87) begin
          case ($urandom_range(0, 3))
            0:       ticks = win_lo;
            1:       ticks = win_lo + 16'd1;
            2:       ticks = win_hi - 16'd1;
            default: ticks = win_hi;
          endcase
        end else begin
          ticks = 16'($urandom);
        end
        pace_requests();
        send_request(ch, ticks, 1'b0, '0);
        if (ch < CHANNELS_DEF) rand_items++;
        if (rand_items == PRESSURE_AT) pressure_go = 1'b1;
      end
    end

    @(negedge clk);
    cap_if.valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (expected_dist_q.size() != 0) begin
      report_mismatch("results still expected at end", 0, expected_dist_q.size());
    end

    $display("Run covered %0d filtered requests, %0d dropped requests and %0d register writes.",
             requests_checked, requests_dropped, writes_done);
    $display("Checked %0d results, %0d of them median replacements, %0d mismatches.",
             results_checked, median_hits, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stall patterns that change at random, plus one long
  // hold-off once the random traffic is under way.
  initial begin
    rdy_mode_e stall_mode;
    int stall_left;
    int mode_left;
    res_if.ready  = 1'b0;
    pressure_done = 1'b0;
    stall_mode    = RDY_ALWAYS;
    stall_left    = 0;
    mode_left     = 0;
    forever begin
      @(negedge clk);
      if (pressure_go && !pressure_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        pressure_done = 1'b1;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (mode_left == 0) begin
          stall_mode = rdy_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(50, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          RDY_COIN:      if ($urandom_range(0, 1) == 1) stall_left = 1;
          RDY_BURSTY:    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
          RDY_RARE_LONG: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_dist_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(res_if.distance), -1);
      end else begin
        want = expected_dist_q.pop_front();
        if (res_if.out_channel !== want.ch) begin
          report_mismatch("out_channel", int'(res_if.out_channel), int'(want.ch));
        end
        if (res_if.distance !== want.dist_val) begin
          report_mismatch("distance", int'(res_if.distance), int'(want.dist_val));
        end
        if (res_if.median_used !== want.med) begin
          report_mismatch("median_used", int'(res_if.median_used), int'(want.med));
        end
        results_checked++;
        if (want.med) median_hits++;
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((cap_if.valid === 1'b1 && cap_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a handshake.", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
